@@ sv/mzma_pkg.sv @@
package mzma_pkg;

  // Block dimensions
  localparam int SAMPLES_PER_ZONE = 5;
  localparam int ZONE_COUNT       = 4;
  localparam int ADC_BITS         = 12;

  // Fixed field widths of the ports
  localparam int ZIN_W    = 3;
  localparam int SMP_IN_W = 12;
  localparam int CAL_W    = 12;
  localparam int PCT_W    = 15;
  localparam int PCT_FULL = 25600;   // 100 percent in Q8

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DRY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WET = 1'b1;
  localparam logic [CAL_W-1:0]     DRY_RESET = {CAL_W{1'b1}};
  localparam logic [CAL_W-1:0]     WET_RESET = '0;

  // Sample store geometry
  localparam int STORE_W     = ADC_BITS;
  localparam int STORE_DEPTH = ZONE_COUNT * SAMPLES_PER_ZONE;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ZIDX_W      = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int POS_W       = (SAMPLES_PER_ZONE > 1) ? $clog2(SAMPLES_PER_ZONE) : 1;
  localparam int CNT_W       = $clog2(SAMPLES_PER_ZONE + 1);
  localparam int SUM_W       = STORE_W + CNT_W;
  localparam logic [SMP_IN_W-1:0] SMP_MASK = SMP_IN_W'((1 << ADC_BITS) - 1);

  // Percentage datapath
  localparam int OPW     = (CAL_W > STORE_W) ? CAL_W : STORE_W;
  localparam int NUM_W   = OPW + PCT_W;
  localparam int DIV_D_W = (CAL_W > CNT_W) ? CAL_W : CNT_W;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  // Front to back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [ZIN_W-1:0]    zone_number;
    logic [SMP_IN_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [PCT_W-1:0] moisture_percent;
    logic             zone_valid;
  } out_word_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CAL_W-1:0]     data;
  } cfg_wr_t;

  // One classified word handed from front to back
  typedef struct packed {
    logic               zone_ok;
    logic [ADDR_W-1:0]  base;
    logic [POS_W-1:0]   off;
    logic [CNT_W-1:0]   count;
    logic [STORE_W-1:0] sample;
  } q_entry_t;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ sv/mzma_ram.sv @@
module mzma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mzma_div.sv @@
module mzma_div (
  input  logic               clk,
  input  logic               rst,
  input  mzma_pkg::div_req_t req,
  output mzma_pkg::div_rsp_t rsp
);
  import mzma_pkg::*;

  logic [DIV_D_W-1:0] rem;
  logic [NUM_W-1:0]   quo;
  logic [DIV_D_W-1:0] den;
  logic [STEP_W-1:0]  cnt;
  logic               busy;
  logic               done;
  logic [DIV_D_W:0]   shifted;
  logic [DIV_D_W:0]   trial;

  // One restoring step: bring in the next numerator bit, try subtracting
  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        quo  <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= STEP_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (!trial[DIV_D_W]) begin
          rem <= trial[DIV_D_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DIV_D_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

@@ sv/mzma_front.sv @@
module mzma_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mzma_pkg::in_word_t in_word,
  output logic               q_push,
  output mzma_pkg::q_entry_t q_entry,
  input  logic               q_full
);
  import mzma_pkg::*;

  logic [POS_W-1:0]  write_position [ZONE_COUNT];
  logic              ring_filled [ZONE_COUNT];
  logic              zone_ok;
  logic [ZIDX_W-1:0] zidx;
  logic [POS_W-1:0]  pos;
  logic              last;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the zone and work out where the sample goes
  always_comb begin
    zone_ok = (in_word.zone_number != '0) &&
              ((ZIN_W + 1)'(in_word.zone_number) <= (ZIN_W + 1)'(ZONE_COUNT));
    zidx    = ZIDX_W'(in_word.zone_number - ZIN_W'(1));
    pos     = write_position[zidx];
    last    = (pos == POS_W'(SAMPLES_PER_ZONE - 1));

    q_entry.zone_ok = zone_ok;
    q_entry.base    = ADDR_W'(ADDR_W'(zidx) * ADDR_W'(SAMPLES_PER_ZONE));
    q_entry.off     = pos;
    q_entry.count   = (ring_filled[zidx] || last) ? CNT_W'(SAMPLES_PER_ZONE)
                                                  : CNT_W'(pos) + CNT_W'(1);
    q_entry.sample  = STORE_W'(in_word.sample & SMP_MASK);
  end

  // Ring positions and wrap flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ZONE_COUNT; i++) begin
        write_position[i] <= '0;
        ring_filled[i]    <= 1'b0;
      end
    end else if (q_push && zone_ok) begin
      if (last) begin
        write_position[zidx] <= '0;
        ring_filled[zidx]    <= 1'b1;
      end else begin
        write_position[zidx] <= pos + POS_W'(1);
      end
    end
  end

endmodule

@@ sv/mzma_queue.sv @@
module mzma_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mzma_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output mzma_pkg::q_entry_t pop_entry,
  output logic               empty
);
  import mzma_pkg::*;

  q_entry_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   fill;

  assign full      = (fill == Q_CNT_W'(Q_DEPTH));
  assign empty     = (fill == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - Q_CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/mzma_back.sv @@
module mzma_back (
  input  logic                clk,
  input  logic                rst,
  input  mzma_pkg::cfg_wr_t   cfg,
  input  logic                q_empty,
  input  mzma_pkg::q_entry_t  q_entry,
  output logic                q_pop,
  output logic                ram_we,
  output logic [mzma_pkg::ADDR_W-1:0]  ram_waddr,
  output logic [mzma_pkg::STORE_W-1:0] ram_wdata,
  output logic [mzma_pkg::ADDR_W-1:0]  ram_raddr,
  input  logic [mzma_pkg::STORE_W-1:0] ram_rdata,
  output mzma_pkg::div_req_t  div_req,
  input  mzma_pkg::div_rsp_t  div_rsp,
  output logic                out_valid,
  input  logic                out_stall,
  output mzma_pkg::out_word_t out_word
);
  import mzma_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WRITE    = 4'd1;
  localparam logic [3:0] S_READ     = 4'd2;
  localparam logic [3:0] S_DRAIN    = 4'd3;
  localparam logic [3:0] S_AVG_GO   = 4'd4;
  localparam logic [3:0] S_AVG_WAIT = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_PCT_GO   = 4'd7;
  localparam logic [3:0] S_PCT_WAIT = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]         state;
  logic [CAL_W-1:0]   dry_level;
  logic [CAL_W-1:0]   wet_level;
  q_entry_t           job;
  logic [POS_W-1:0]   rd_idx;
  logic               rd_vld;
  logic [SUM_W-1:0]   sum;
  logic [STORE_W-1:0] avg;
  logic [NUM_W-1:0]   prod;
  logic               num_neg;
  logic [CAL_W-1:0]   den_mag;
  logic               den_neg;
  logic               den_zero;
  logic [PCT_W-1:0]   res_pct;
  logic               res_zv;
  logic               out_free;
  logic [OPW:0]       dry_ext;
  logic [OPW:0]       avg_ext;
  logic               diff_neg;
  logic [OPW-1:0]     diff_mag;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || !out_stall;

  // Store port: sample write, then a sweep over the counted entries
  assign ram_we    = (state == S_WRITE);
  assign ram_waddr = job.base + ADDR_W'(job.off);
  assign ram_wdata = job.sample;
  assign ram_raddr = job.base + ADDR_W'(rd_idx);

  // Shared divider: first the average, then the percentage
  always_comb begin
    div_req.start = (state == S_AVG_GO) || (state == S_PCT_GO && !den_zero && !(num_neg ^ den_neg));
    div_req.num   = (state == S_AVG_GO) ? NUM_W'(sum) : prod;
    div_req.den   = (state == S_AVG_GO) ? DIV_D_W'(job.count) : DIV_D_W'(den_mag);
  end

  // Signed difference dry - avg as sign and magnitude
  always_comb begin
    dry_ext  = (OPW + 1)'(dry_level);
    avg_ext  = (OPW + 1)'(avg);
    diff_neg = avg_ext > dry_ext;
    diff_mag = diff_neg ? OPW'(avg_ext - dry_ext) : OPW'(dry_ext - avg_ext);
  end

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dry_level <= DRY_RESET;
      wet_level <= WET_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DRY: dry_level <= cfg.data;
        REG_WET: wet_level <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job <= q_entry;
            if (q_entry.zone_ok) begin
              state <= S_WRITE;
            end else begin
              res_pct <= '0;
              res_zv  <= 1'b0;
              state   <= S_DONE;
            end
          end
        end
        S_WRITE: begin
          sum    <= '0;
          rd_idx <= '0;
          rd_vld <= 1'b0;
          state  <= S_READ;
        end
        S_READ: begin
          rd_vld <= 1'b1;
          if (rd_vld) begin
            sum <= sum + SUM_W'(ram_rdata);
          end
          if (rd_idx == POS_W'(job.count - CNT_W'(1))) begin
            state <= S_DRAIN;
          end else begin
            rd_idx <= rd_idx + POS_W'(1);
          end
        end
        S_DRAIN: begin
          sum    <= sum + SUM_W'(ram_rdata);
          rd_vld <= 1'b0;
          state  <= S_AVG_GO;
        end
        S_AVG_GO: begin
          state <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (div_rsp.done) begin
            avg   <= div_rsp.quot[STORE_W-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod     <= NUM_W'(diff_mag) * NUM_W'(PCT_FULL);
          num_neg  <= diff_neg;
          den_neg  <= wet_level > dry_level;
          den_zero <= wet_level == dry_level;
          den_mag  <= (wet_level > dry_level) ? wet_level - dry_level
                                              : dry_level - wet_level;
          state    <= S_PCT_GO;
        end
        S_PCT_GO: begin
          res_zv <= 1'b1;
          // Equal levels or a negative quotient end at zero
          if (den_zero || (num_neg ^ den_neg)) begin
            res_pct <= '0;
            state   <= S_DONE;
          end else begin
            state <= S_PCT_WAIT;
          end
        end
        S_PCT_WAIT: begin
          if (div_rsp.done) begin
            res_pct <= (div_rsp.quot > NUM_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
                                                          : div_rsp.quot[PCT_W-1:0];
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_word.moisture_percent <= res_pct;
      out_word.zone_valid       <= res_zv;
    end
  end

endmodule

@@ sv/multi_zone_moisture_averager.sv @@
// Channel   Handshake            Word
// in        in_valid / in_stall  in_word   (zone_number, sample)
// out       out_valid / out_stall out_word (moisture_percent, zone_valid)
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data (0 dry_level, 1 wet_level)
//
// A word in a valid zone takes one store read per counted entry, then a pass
// through the bit-serial divider for the average and, unless the result is
// forced to zero, one for the percentage. A rejected zone skips both.
// Reset is synchronous; it empties the rings and loads dry 4095, wet 0.
// A two-word queue parts input from the sequencer, and the output register
// lets the next word start while a result waits on out_stall.
module multi_zone_moisture_averager (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mzma_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mzma_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mzma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mzma_pkg::CAL_W-1:0]          cfg_data
);
  import mzma_pkg::*;

  q_entry_t            push_entry;
  q_entry_t            pop_entry;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  cfg_wr_t             cfg;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [STORE_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [STORE_W-1:0]  ram_rdata;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // Registers accept a write every cycle
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  mzma_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_push   (q_push),
    .q_entry  (push_entry),
    .q_full   (q_full)
  );

  mzma_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  mzma_ram #(
    .WIDTH (STORE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mzma_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  mzma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

@@ tb/tb_multi_zone_moisture_averager.sv @@
module tb_multi_zone_moisture_averager;
  timeunit 1ns;
  timeprecision 1ps;

  import mzma_pkg::*;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0]     cfg_data  = '0;

  multi_zone_moisture_averager dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of calibration and ring state
  logic [CAL_W-1:0]   cal_dry;
  logic [CAL_W-1:0]   cal_wet;
  logic [STORE_W-1:0] ring_mem [ZONE_COUNT][SAMPLES_PER_ZONE];
  int unsigned        ring_pos [ZONE_COUNT];
  bit                 ring_full [ZONE_COUNT];

  in_word_t  pending_words [$];
  out_word_t moisture_due [$];

  // Handshake bookkeeping and pacing
  logic in_fired  = 1'b0;
  logic out_fired = 1'b0;
  bit   no_idle   = 1'b0;
  int   send_gap    = 0;
  int   stall_left  = 0;
  int   hold_left   = 0;
  int   hold_reqs   = 0;
  int   hold_served = 0;

  // Run statistics
  int mismatch_count  = 0;
  int words_in        = 0;
  int invalid_words   = 0;
  int results_checked = 0;
  int full_scale      = 0;
  int cal_settings    = 0;

  // Ring update plus averaged, calibrated percentage for one word
  function automatic out_word_t predict_moisture(in_word_t w);
    out_word_t   res;
    int unsigned z;
    int unsigned n;
    int unsigned total;
    int unsigned avg;
    longint      span;
    longint      q;
    res = '0;
    if (w.zone_number < 1 || w.zone_number > ZONE_COUNT) return res;
    z = w.zone_number - 1;
    ring_mem[z][ring_pos[z]] = w.sample & SMP_MASK;
    ring_pos[z]++;
    if (ring_pos[z] == SAMPLES_PER_ZONE) begin
      ring_pos[z]  = 0;
      ring_full[z] = 1'b1;
    end
    n = ring_full[z] ? SAMPLES_PER_ZONE : ring_pos[z];
    total = 0;
    for (int i = 0; i < n; i++) total += ring_mem[z][i];
    avg  = total / n;
    span = longint'(cal_dry) - longint'(cal_wet);
    q    = 0;
    if (span != 0) begin
      // signed division truncates toward zero
      q = (longint'(cal_dry) - longint'(avg)) * PCT_FULL / span;
      if (q < 0) q = 0;
      if (q > PCT_FULL) q = PCT_FULL;
    end
    res.moisture_percent = q[PCT_W-1:0];
    res.zone_valid       = 1'b1;
    return res;
  endfunction

  function automatic void flag_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    if (mismatch_count < 10)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
    mismatch_count++;
  endfunction

  function automatic void queue_word(int zone, int smp);
    in_word_t w;
    w.zone_number = zone[ZIN_W-1:0];
    w.sample      = smp[SMP_IN_W-1:0];
    pending_words.push_back(w);
  endfunction

  // Monitor: predict on accepted input, check accepted output
  always @(posedge clk) begin : monitor
    out_word_t due;
    in_fired  <= !rst && in_valid && !in_stall;
    out_fired <= !rst && out_valid && !out_stall;
    if (!rst && in_valid && !in_stall) begin
      moisture_due.push_back(predict_moisture(in_word));
      words_in++;
      if (in_word.zone_number < 1 || in_word.zone_number > ZONE_COUNT) invalid_words++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (moisture_due.size() == 0) begin
        flag_mismatch("result with nothing outstanding", 0, 32'(out_word));
      end else begin
        due = moisture_due.pop_front();
        results_checked++;
        if (due.moisture_percent == 0 || due.moisture_percent == PCT_FULL) full_scale++;
        if (out_word.moisture_percent !== due.moisture_percent)
          flag_mismatch("moisture_percent", 32'(due.moisture_percent),
                        32'(out_word.moisture_percent));
        if (out_word.zone_valid !== due.zone_valid)
          flag_mismatch("zone_valid", 32'(due.zone_valid), 32'(out_word.zone_valid));
      end
    end
  end

  // Input driver: one word per queue entry, random gap after each (none when no_idle)
  always @(negedge clk) begin : drive_in
    logic     nv;
    in_word_t nw;
    nv = in_valid;
    nw = in_word;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_fired) nv = 1'b0;
      if (!nv) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_words.size() != 0) begin
          nw = pending_words.pop_front();
          nv = 1'b1;
          send_gap = no_idle ? 0 : $urandom_range(0, 6);
        end
      end
    end
    in_valid <= nv;
    in_word  <= nw;
  end

  // Output side: per-result stall, plus long hold-off on request
  always @(negedge clk) begin : drive_out
    logic ns;
    ns = 1'b0;
    if (!rst) begin
      if (hold_reqs != hold_served) begin
        hold_left   = 600;
        hold_served = hold_reqs;
      end
      if (out_fired) stall_left = no_idle ? 0 : $urandom_range(0, 6);
      if (hold_left != 0) begin
        hold_left--;
        ns = 1'b1;
      end else if (stall_left != 0 && out_valid) begin
        stall_left--;
        ns = 1'b1;
      end else if (!no_idle && !out_valid) begin
        ns = ($urandom_range(0, 3) == 0);
      end
    end
    out_stall <= ns;
  end

  // Writes dry then wet through the config channel; block must be idle
  task automatic set_calibration(input logic [CAL_W-1:0] dry, input logic [CAL_W-1:0] wet);
    for (int r = 0; r < 2; r++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= (r == 0) ? REG_DRY : REG_WET;
      cfg_data  <= (r == 0) ? dry : wet;
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      if (cfg_index == REG_DRY) cal_dry = cfg_data;
      else cal_wet = cfg_data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    cal_settings++;
  endtask

  // Sender pause: hold until every outstanding result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || moisture_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    int plan_dry [10];
    int plan_wet [10];
    int lo;
    int hi;
    in_word_t w;
    plan_dry = '{4095, 0, 2048, 0, 4095, 3000, 1000, 2001, 0, 0};
    plan_wet = '{0, 4095, 2048, 0, 4095, 1000, 3000, 2000, 0, 0};
    cal_dry = DRY_RESET;
    cal_wet = WET_RESET;
    for (int z = 0; z < ZONE_COUNT; z++) begin
      ring_pos[z]  = 0;
      ring_full[z] = 1'b0;
      for (int i = 0; i < SAMPLES_PER_ZONE; i++) ring_mem[z][i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: rejected zones, extremes, partial and wrapped rings
    queue_word(0, 0);
    queue_word(5, 4095);
    queue_word(6, 'h555);
    queue_word(7, 'hAAA);
    queue_word(1, 4095);
    queue_word(1, 0);
    queue_word(1, 'h800);
    repeat (5) queue_word(2, 4095);
    queue_word(2, 0);
    repeat (5) queue_word(3, 0);
    queue_word(3, 4095);
    queue_word(4, 'hAAA);
    queue_word(4, 'h555);
    wait_drained();

    // Equal calibration levels: zero, but the sample still lands in the ring
    set_calibration(CAL_W'(2048), CAL_W'(2048));
    @(posedge clk);
    queue_word(1, 100);
    queue_word(0, 100);
    wait_drained();

    // Wet above dry
    set_calibration(CAL_W'(0), CAL_W'(4095));
    @(posedge clk);
    queue_word(4, 1000);
    queue_word(3, 4095);
    wait_drained();

    // Random phases, one calibration setting each
    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 8) begin
        set_calibration(CAL_W'(plan_dry[ph]), CAL_W'(plan_wet[ph]));
      end else begin
        set_calibration(CAL_W'($urandom_range(0, 4095)), CAL_W'($urandom_range(0, 4095)));
      end
      no_idle = (ph == 3 || ph == 6);
      lo = (cal_dry < cal_wet) ? int'(cal_dry) : int'(cal_wet);
      hi = (cal_dry < cal_wet) ? int'(cal_wet) : int'(cal_dry);
      @(posedge clk);
      for (int k = 0; k < 170; k++) begin
        if ($urandom_range(0, 99) < 85) w.zone_number = ZIN_W'($urandom_range(1, ZONE_COUNT));
        else w.zone_number = ZIN_W'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
          0:       w.sample = $urandom_range(0, 1) ? {SMP_IN_W{1'b1}} : '0;
          1:       w.sample = SMP_IN_W'($urandom);
          default: w.sample = SMP_IN_W'($urandom_range(lo, hi));
        endcase
        pending_words.push_back(w);
      end
      // long output hold-off so the block backs up into its input
      if (ph == 5) hold_reqs++;
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (100) @(posedge clk);
    while (moisture_due.size() != 0) begin
      w = '0;
      flag_mismatch("result never produced", 32'(moisture_due.pop_front()), 0);
    end
    $display("Covered %0d words (%0d in rejected zones), %0d results checked,",
             words_in, invalid_words, results_checked);
    $display("  %0d at 0 or 100 percent, across %0d calibration settings",
             full_scale, cal_settings);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_200_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
sv/mzma_pkg.sv
sv/mzma_ram.sv
sv/mzma_div.sv
sv/mzma_front.sv
sv/mzma_queue.sv
sv/mzma_back.sv
sv/multi_zone_moisture_averager.sv
tb/tb_multi_zone_moisture_averager.sv
